// ===== src/stack_expression_evaluator_assert.svh =====
// Assertion macros for the stack expression evaluator checker.
// Needs nothing else; the checker file includes it.
`ifndef STACK_EXPRESSION_EVALUATOR_ASSERT_SVH
`define STACK_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== src/sse_pkg.sv =====
// Shared types and constants for the stack expression evaluator.
// Used by the controller, datapath, top level and checker.
package sse_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCENT = 8'h25;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_DIVZERO   = 2'd3
    } err_code_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_NONE
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_SETTLE,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic      latch;
        logic      push_digit;
        logic      commit;
        logic      commit_div;
        logic      pop2;
        logic      drop_all;
        logic      flag_en;
        err_code_t flag_code;
        logic      start_div;
        logic      out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic     is_digit;
        logic     few_operands;
        op_kind_t op_kind;
        logic     div_zero;
        logic     div_done;
        logic     last;
        logic     out_free;
    } dp_status_t;

endpackage

// ===== src/sse_divider.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, C truncation.
// Depends on sse_pkg for the word width.
module sse_divider (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [sse_pkg::WORD_W-1:0]  dividend,
    input  logic signed [sse_pkg::WORD_W-1:0]  divisor,
    output logic                               done,
    output logic        [sse_pkg::WORD_W-1:0]  quotient,
    output logic        [sse_pkg::WORD_W-1:0]  remainder
);
    localparam int W  = sse_pkg::WORD_W;
    localparam int NW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dsr_reg;
    logic          neg_q_reg;
    logic          neg_r_reg;

    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign mag_a   = dividend[W-1] ? (~dividend + W'(1)) : dividend;
    assign mag_b   = divisor[W-1]  ? (~divisor + W'(1))  : divisor;
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - NW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            quo_reg   <= mag_a;
            dsr_reg   <= mag_b;
            neg_q_reg <= dividend[W-1] ^ divisor[W-1];
            neg_r_reg <= dividend[W-1];
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + W'(1)) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + W'(1)) : rem_reg;

endmodule

// ===== src/sse_datapath.sv =====
// Datapath: operand stack memory, ALU, divider and output register.
// Depends on sse_pkg and sse_divider; driven by sse_ctrl commands.
module sse_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    input  sse_pkg::ctrl_cmd_t                cmd,
    output sse_pkg::dp_status_t               status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [sse_pkg::WORD_W-1:0] m_tdata,
    output logic [1:0]                        m_tuser
);
    localparam int W  = sse_pkg::WORD_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [W-1:0]        stack_mem [STACK_DEPTH];
    logic [W-1:0]        top_reg;
    logic [W-1:0]        next_reg;
    logic [7:0]          sym_reg;
    logic                last_reg;
    logic                mode_reg;
    logic [CW-1:0]       count_reg, count_next;
    sse_pkg::err_code_t  err_reg, err_next;
    logic                out_valid_reg, out_valid_next;
    logic [W-1:0]        out_value_reg;
    sse_pkg::err_code_t  out_status_reg;

    logic [CW-1:0]       cnt_m1, cnt_m2;
    logic [AW-1:0]       rd_top_addr, rd_next_addr;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [W-1:0]        wdata;
    logic                full;
    logic                is_digit;
    sse_pkg::op_kind_t   op_kind;
    logic [W-1:0]        opa, opb;
    logic [2*W-1:0]      mul_full;
    logic [W-1:0]        alu_res;
    logic [W-1:0]        div_res;
    logic                div_done;
    logic [W-1:0]        quotient, remainder;
    sse_pkg::err_code_t  final_err;
    logic [7:0]          digit_val;

    assign cnt_m1       = count_reg - CW'(1);
    assign cnt_m2       = count_reg - CW'(2);
    assign rd_top_addr  = cnt_m1[AW-1:0];
    assign rd_next_addr = cnt_m2[AW-1:0];
    assign full         = (count_reg == CW'(STACK_DEPTH));
    assign digit_val    = sym_reg - sse_pkg::CH_ZERO;

    // Symbol decode; postfix folds any unknown symbol into modulo
    always_comb begin
        is_digit = sym_reg inside {[sse_pkg::CH_ZERO:sse_pkg::CH_NINE]};
        case (sym_reg)
            sse_pkg::CH_PLUS:  op_kind = sse_pkg::OP_ADD;
            sse_pkg::CH_MINUS: op_kind = sse_pkg::OP_SUB;
            sse_pkg::CH_STAR:  op_kind = sse_pkg::OP_MUL;
            sse_pkg::CH_SLASH: op_kind = sse_pkg::OP_DIV;
            sse_pkg::CH_PCENT: op_kind = sse_pkg::OP_MOD;
            default:           op_kind = mode_reg ? sse_pkg::OP_NONE : sse_pkg::OP_MOD;
        endcase
    end

    // Prefix takes top op next, postfix next op top
    assign opa      = mode_reg ? top_reg : next_reg;
    assign opb      = mode_reg ? next_reg : top_reg;
    assign mul_full = opa * opb;

    always_comb begin
        case (op_kind)
            sse_pkg::OP_ADD: alu_res = opa + opb;
            sse_pkg::OP_SUB: alu_res = opa - opb;
            sse_pkg::OP_MUL: alu_res = mul_full[W-1:0];
            default:         alu_res = '0;
        endcase
    end

    sse_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.start_div),
        .dividend  (opa),
        .divisor   (opb),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign div_res = (op_kind == sse_pkg::OP_MOD) ? remainder : quotient;

    // Single write port
    always_comb begin
        we    = 1'b0;
        waddr = rd_next_addr;
        wdata = alu_res;
        if (cmd.push_digit && !full) begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = {{(W-4){1'b0}}, digit_val[3:0]};
        end else if (cmd.commit || cmd.commit_div) begin
            we    = 1'b1;
            waddr = rd_next_addr;
            wdata = cmd.commit_div ? div_res : alu_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            stack_mem[waddr] <= wdata;
        end
        top_reg  <= stack_mem[rd_top_addr];
        next_reg <= stack_mem[rd_next_addr];
    end

    always_comb begin
        final_err = err_reg;
        if (err_reg == sse_pkg::ERR_NONE && count_reg == '0) begin
            final_err = sse_pkg::ERR_UNDERFLOW;
        end
    end

    always_comb begin
        count_next     = count_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.push_digit) begin
            if (full) begin
                if (err_reg == sse_pkg::ERR_NONE) begin
                    err_next = sse_pkg::ERR_OVERFLOW;
                end
            end else begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.commit || cmd.commit_div) begin
            count_next = cnt_m1;
        end
        if (cmd.pop2) begin
            count_next = cnt_m2;
        end
        if (cmd.drop_all) begin
            count_next = '0;
        end
        if (cmd.flag_en && err_reg == sse_pkg::ERR_NONE) begin
            err_next = cmd.flag_code;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            count_next     = '0;
            err_next       = sse_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            err_reg       <= sse_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
        end else begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            sym_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.out_load) begin
            out_status_reg <= final_err;
            out_value_reg  <= (final_err == sse_pkg::ERR_NONE) ? top_reg : '0;
        end
    end

    assign status.is_digit     = is_digit;
    assign status.few_operands = (count_reg < CW'(2));
    assign status.op_kind      = op_kind;
    assign status.div_zero     = (opb == '0);
    assign status.div_done     = div_done;
    assign status.last         = last_reg;
    assign status.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== src/sse_ctrl.sv =====
// Controller state machine: sequences decode, divide and result delivery.
// Depends on sse_pkg; issues commands to sse_datapath.
module sse_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sse_pkg::dp_status_t status,
    output sse_pkg::ctrl_cmd_t  cmd
);
    sse_pkg::state_t state_reg, state_next;
    sse_pkg::state_t after_state;

    assign after_state = status.last ? sse_pkg::ST_SETTLE : sse_pkg::ST_IDLE;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sse_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = sse_pkg::ST_DECODE;
            end
            sse_pkg::ST_DECODE: begin
                if (!status.is_digit && !status.few_operands && !status.div_zero &&
                    (status.op_kind == sse_pkg::OP_DIV ||
                     status.op_kind == sse_pkg::OP_MOD)) begin
                    state_next = sse_pkg::ST_DIVIDE;
                end else begin
                    state_next = after_state;
                end
            end
            sse_pkg::ST_DIVIDE: begin
                if (status.div_done) state_next = after_state;
            end
            sse_pkg::ST_SETTLE: begin
                state_next = sse_pkg::ST_FINISH;
            end
            sse_pkg::ST_FINISH: begin
                if (status.out_free) state_next = sse_pkg::ST_IDLE;
            end
            default: state_next = sse_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        case (state_reg)
            sse_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            sse_pkg::ST_DECODE: begin
                if (status.is_digit) begin
                    cmd.push_digit = 1'b1;
                end else if (status.few_operands) begin
                    cmd.drop_all  = 1'b1;
                    cmd.flag_en   = 1'b1;
                    cmd.flag_code = sse_pkg::ERR_UNDERFLOW;
                end else begin
                    case (status.op_kind)
                        sse_pkg::OP_NONE: cmd.pop2 = 1'b1;
                        sse_pkg::OP_DIV, sse_pkg::OP_MOD: begin
                            if (status.div_zero) begin
                                cmd.commit    = 1'b1;
                                cmd.flag_en   = 1'b1;
                                cmd.flag_code = sse_pkg::ERR_DIVZERO;
                            end else begin
                                cmd.start_div = 1'b1;
                            end
                        end
                        default: cmd.commit = 1'b1;
                    endcase
                end
            end
            sse_pkg::ST_DIVIDE: begin
                cmd.commit_div = status.div_done;
            end
            sse_pkg::ST_FINISH: begin
                cmd.out_load = status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sse_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/stack_expression_evaluator.sv =====
// Top level of the stack expression evaluator.
// Depends on sse_pkg, sse_ctrl, sse_datapath (and sse_divider below it).
//
// Usage:
//   s_ channel: one beat per expression character. s_tdata[7:0] holds the
//   ASCII symbol; s_tlast marks the final character of an expression.
//   m_ channel: one beat per expression, after its last character.
//   cfg_we/cfg_wdata: write prefix_mode (0 postfix, 1 prefix fed right to
//   left). Write only while the block is idle.
// Sequence:
//   A digit or + - * is accepted, then decoded. / and % with a nonzero
//   divisor then wait in a divide state for the one-bit-per-cycle iterative
//   divider. The last character adds a final stack read and an output load
//   before the result beat appears.
//   One character is in flight at a time.
// Reset and stall:
//   Reset empties the stack, clears the error and selects postfix mode.
//   The result sits in an output register; the block takes new characters
//   while it waits, and only stalls at the next expression end until the
//   previous result has been taken.
module stack_expression_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    // characters in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] symbol
    input  logic                              s_tlast,   // last
    // results out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [sse_pkg::WORD_W-1:0] m_tdata,   // [31:0] value
    output logic [1:0]                        m_tuser    // [1:0] status
);

    sse_pkg::ctrl_cmd_t  cmd;
    sse_pkg::dp_status_t status;

    // Sequence each character
    sse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the stack, compute, and drive the result beat
    sse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== src/sse_port_checker.sv =====
// Port-level checker for the stack expression evaluator, bound to the top.
// Depends on sse_pkg and stack_expression_evaluator_assert.svh.
`include "stack_expression_evaluator_assert.svh"

module sse_port_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic signed [sse_pkg::WORD_W-1:0] m_tdata,
    input logic [1:0]                        m_tuser
);

    // A stalled result beat holds
    `SSE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // An error result carries a zero value
    `SSE_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != sse_pkg::ERR_NONE), m_tdata == '0)

    // One character at a time: busy the cycle after an accepted beat
    `SSE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A new result only appears while a character is at work
    `SSE_ASSERT_NOW(a_result_from_work, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))

endmodule

bind stack_expression_evaluator sse_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/tb_stack_expression_evaluator.sv =====
// Self-checking testbench for the stack expression evaluator: it streams expression
// characters in both modes and compares every reported value and status with its own model.
// Depends on sse_pkg and stack_expression_evaluator only.
`timescale 1ns / 100ps

module tb_stack_expression_evaluator;

    localparam int STACK_DEPTH = 16;
    // Longest operation is a divide plus the final stack read.
    localparam int SETTLE_CYCLES = 40;
    localparam int BEATS_PER_PHASE = 240;

    typedef struct packed {
        logic signed [sse_pkg::WORD_W-1:0] value;
        sse_pkg::err_code_t                status;
    } eval_result_t;

    // Mirror of the evaluator: operand stack, sticky error and mode, plus the
    // answers still owed by the block.
    class expr_checker;
        logic [sse_pkg::WORD_W-1:0] operands [STACK_DEPTH];
        int                         depth_used = 0;
        sse_pkg::err_code_t         held_err = sse_pkg::ERR_NONE;
        bit                         prefix = 1'b0;
        eval_result_t               pending_answers [$];
        int unsigned                mismatches = 0;

        function void note_error(sse_pkg::err_code_t code);
            if (held_err == sse_pkg::ERR_NONE) held_err = code;
        endfunction

        function void push_operand(logic [sse_pkg::WORD_W-1:0] v);
            if (depth_used >= STACK_DEPTH) begin
                note_error(sse_pkg::ERR_OVERFLOW);
                return;
            end
            operands[depth_used] = v;
            depth_used++;
        endfunction

        function bit pop_operand(output logic [sse_pkg::WORD_W-1:0] v);
            if (depth_used == 0) begin
                v = '0;
                return 1'b0;
            end
            depth_used--;
            v = operands[depth_used];
            return 1'b1;
        endfunction

        function logic [sse_pkg::WORD_W-1:0] apply_op(logic [7:0] op,
                                                      logic [sse_pkg::WORD_W-1:0] a,
                                                      logic [sse_pkg::WORD_W-1:0] b);
            case (op)
                sse_pkg::CH_PLUS:  return a + b;
                sse_pkg::CH_MINUS: return a - b;
                sse_pkg::CH_STAR:  return a * b;
                default: ;
            endcase
            if (b == '0) begin
                note_error(sse_pkg::ERR_DIVZERO);
                return '0;
            end
            // Most negative over minus one wraps; keep it away from native division.
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                return (op == sse_pkg::CH_SLASH) ? a : '0;
            if (op == sse_pkg::CH_SLASH) return $signed(a) / $signed(b);
            return $signed(a) % $signed(b);
        endfunction

        function void accept_symbol(logic [7:0] sym, logic last);
            logic [sse_pkg::WORD_W-1:0] top_v, next_v, out_v;
            logic [7:0]                 op;
            bit                         got_top, got_next;
            eval_result_t               answer;
            if (sym >= sse_pkg::CH_ZERO && sym <= sse_pkg::CH_NINE) begin
                push_operand(sse_pkg::WORD_W'(sym - sse_pkg::CH_ZERO));
            end else begin
                got_top  = pop_operand(top_v);
                got_next = pop_operand(next_v);
                if (!(got_top && got_next)) begin
                    note_error(sse_pkg::ERR_UNDERFLOW);
                end else if (prefix) begin
                    // Unknown symbols consume both operands and push nothing.
                    if (sym == sse_pkg::CH_PLUS || sym == sse_pkg::CH_MINUS ||
                        sym == sse_pkg::CH_STAR || sym == sse_pkg::CH_SLASH ||
                        sym == sse_pkg::CH_PCENT)
                        push_operand(apply_op(sym, top_v, next_v));
                end else begin
                    op = (sym == sse_pkg::CH_PLUS || sym == sse_pkg::CH_MINUS ||
                          sym == sse_pkg::CH_STAR || sym == sse_pkg::CH_SLASH) ?
                         sym : sse_pkg::CH_PCENT;
                    push_operand(apply_op(op, next_v, top_v));
                end
            end
            if (!last) return;
            if (!pop_operand(out_v)) note_error(sse_pkg::ERR_UNDERFLOW);
            answer.value  = (held_err == sse_pkg::ERR_NONE) ? out_v : '0;
            answer.status = held_err;
            pending_answers.push_back(answer);
            depth_used = 0;
            held_err   = sse_pkg::ERR_NONE;
        endfunction

        function void check_answer(logic signed [sse_pkg::WORD_W-1:0] value,
                                   logic [1:0] status);
            eval_result_t want;
            if (pending_answers.size() == 0) begin
                $display("%0t: result with none outstanding, expected none, actual value %0d status %0d",
                         $time, value, status);
                mismatches++;
                return;
            end
            want = pending_answers.pop_front();
            if (value !== want.value) begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, want.value, value);
                mismatches++;
            end
            if (status !== 2'(want.status)) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, status);
                mismatches++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;    // [7:0] symbol
    logic              s_tlast = 1'b0;  // last
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic signed [sse_pkg::WORD_W-1:0] m_tdata;  // [31:0] value
    logic [1:0]        m_tuser;         // [1:0] status

    int                tx_idle_pct = 24;
    int                rx_idle_pct = 58;
    int                beats_sent = 0;
    expr_checker       chk = new();

    stack_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result side: check each accepted beat against the oldest answer owed,
    // then pick the next cycle's ready at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            chk.check_answer(m_tdata, m_tuser);
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Offer one character, idling first at the current rate, and hold it
    // until the block takes it.
    task automatic send_beat(input logic [7:0] sym, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chk.accept_symbol(sym, last);
        beats_sent++;
    endtask

    task automatic send_text(input string text, input bit terminate);
        for (int i = 0; i < text.len(); i++) begin
            send_beat(text[i], terminate && (i == text.len() - 1));
        end
    endtask

    // Drop valid and hold off until every answer owed has come back.
    task automatic hold_until_answered();
        s_tvalid <= 1'b0;
        while (chk.pending_answers.size() != 0) @(posedge aclk);
    endtask

    // Write the mode only once the block has gone quiet.
    task automatic select_mode(input bit prefix_on);
        hold_until_answered();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= prefix_on;
        chk.prefix = prefix_on;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random well-formed expression. The shape is operand, operand, operator
    // in both modes: in prefix mode it reads as a reversed prefix string.
    function automatic string random_tree(input int levels);
        string      ops = "+-*/%";
        logic [7:0] op;
        if (levels == 0 || $urandom_range(3) == 0)
            return $sformatf("%c", sse_pkg::CH_ZERO + 8'($urandom_range(9)));
        op = ops[$urandom_range(4)];
        // Now and then slip in a non-operator symbol.
        if ($urandom_range(19) == 0) op = 8'($urandom_range(122, 65));
        return {random_tree(levels - 1), random_tree(levels - 1), $sformatf("%c", op)};
    endfunction

    task automatic random_phase(input bit prefix_on, input int tx_pct, input int rx_pct);
        string alphabet = "0123456789+-*/%";
        string text;
        int    goal;
        int    len;
        bit    paused;
        select_mode(prefix_on);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal   = beats_sent + BEATS_PER_PHASE;
        paused = 1'b0;
        while (beats_sent < goal) begin
            len = $urandom_range(99);
            if (len < 75) begin
                send_text(random_tree($urandom_range(5)), 1'b1);
            end else if (len < 88) begin
                // Broken sequence: digits and operators in any order, long
                // enough at times to overrun the stack.
                text = "";
                len  = $urandom_range(20, 1);
                for (int i = 0; i < len; i++) begin
                    text = {text, $sformatf("%c", alphabet[$urandom_range(14)])};
                end
                send_text(text, 1'b1);
            end else begin
                // Raw bytes; the expression may run on into the next one.
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++) begin
                    send_beat(8'($urandom_range(255)), (i == len - 1) && $urandom_range(1));
                end
            end
            if (!paused && beats_sent >= goal - BEATS_PER_PHASE / 2) begin
                hold_until_answered();
                paused = 1'b1;
            end
        end
        // Close any expression left open so the phase ends clean.
        send_text("1", 1'b1);
    endtask

    initial begin
        string postfix_cases [$];
        string prefix_cases [$];
        postfix_cases = '{
            "0", "9", "95-", "59-", "98*", "72/", "72%", "07-2/", "07-2%",
            "702-/", "702-%", "50/", "50%", "3+", "+", "72a",
            "0123456789012345678",
            "88*8*8*8*8*8*8*8*8*2*01-/",
            "88*8*8*8*8*8*8*8*8*2*01-%",
            "99*9*9*9*9*9*9*9*9*9*9*"
        };
        prefix_cases = '{
            "27/", "27-", "27%", "27*", "27+", "27a", "527a", "07/", "07%", "+",
            "10-88*8*8*8*8*8*8*8*8*2*/",
            "10-88*8*8*8*8*8*8*8*8*2*%"
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: both modes, field extremes and each corner of the stack.
        select_mode(1'b0);
        foreach (postfix_cases[i]) send_text(postfix_cases[i], 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        select_mode(1'b1);
        foreach (prefix_cases[i]) send_text(prefix_cases[i], 1'b1);

        // Random: slow receiver first, then slow sender, then flat out.
        random_phase(1'b0, 24, 58);
        random_phase(1'b1, 24, 58);
        random_phase(1'b1, 58, 24);
        random_phase(1'b0, 58, 24);
        random_phase(1'b0, 0, 0);
        random_phase(1'b1, 0, 0);

        hold_until_answered();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (chk.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
